>>> hdl/lp2d_pkg.sv
`default_nettype none

package lp2d_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FINE_BITS      = 18;
    localparam int SLOPE_BITS     = 20;
    localparam int COORD_BITS     = 10;
    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TILE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TILE_HEIGHT = 2'd1;

    localparam logic [CFG_BITS-1:0] TILE_RESET = 11'd1024;
    localparam logic [CFG_BITS-1:0] TILE_MIN   = 11'd3;
    localparam logic [CFG_BITS-1:0] MAX_ROWS   = 11'd1024;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [FINE_BITS-1:0]   fine_t;
    typedef logic signed [SLOPE_BITS-1:0]  slope_t;
    typedef logic        [COORD_BITS-1:0]  coord_t;

    // slope towards corner a, limited by corner b; zero when fb is not between them
    function automatic slope_t limited_slope(fine_t fb, fine_t a, fine_t b);
        logic signed [FINE_BITS:0] da;
        logic signed [FINE_BITS:0] db;
        logic        [FINE_BITS:0] ma;
        logic        [FINE_BITS:0] mb;
        logic        [FINE_BITS:0] m;
        slope_t                    mag;
        slope_t                    r;
        da  = (FINE_BITS+1)'(fb) - (FINE_BITS+1)'(a);
        db  = (FINE_BITS+1)'(b) - (FINE_BITS+1)'(fb);
        ma  = da[FINE_BITS] ? (~da + 1'b1) : da;
        mb  = db[FINE_BITS] ? (~db + 1'b1) : db;
        m   = (ma < mb) ? ma : mb;
        mag = slope_t'({1'b0, m});
        if ((db < 0 && da > 0) || (db > 0 && da < 0))
        begin
            r = '0;
        end
        else if (da < 0)
        begin
            r = -mag;
        end
        else
        begin
            r = mag;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lp2d_in_if.sv
`default_nettype none

interface lp2d_in_if import lp2d_pkg::*; ();

    logic    valid;
    logic    ready;
    sample_t coarse_sample;

    modport source (output valid, output coarse_sample, input ready);
    modport sink   (input valid, input coarse_sample, output ready);

endinterface

`default_nettype wire

>>> hdl/lp2d_out_if.sv
`default_nettype none

interface lp2d_out_if import lp2d_pkg::*; ();

    logic   valid;
    logic   ready;
    fine_t  fine_low_low;
    fine_t  fine_high_low;
    fine_t  fine_low_high;
    fine_t  fine_high_high;
    coord_t cell_column;
    coord_t cell_row;
    logic   tile_done;

    modport source (
        output valid, output fine_low_low, output fine_high_low, output fine_low_high,
        output fine_high_high, output cell_column, output cell_row, output tile_done,
        input ready
    );
    modport sink (
        input valid, input fine_low_low, input fine_high_low, input fine_low_high,
        input fine_high_high, input cell_column, input cell_row, input tile_done,
        output ready
    );

endinterface

`default_nettype wire

>>> hdl/limited_2x_prolongation_2d_core.sv
// 2x prolongation of a 2D tile with a minmod slope limiter.
// coarse: one signed sample per word, raster order (columns, then rows).
// fine:   one word per interior cell: four fine values in quarter units,
//         cell column and row, tile_done on the last interior cell.
// Edge cells give no word; cell (i,j) leaves after sample (i+1,j+1) goes in.
// cfg: write tile_width (index 0) or tile_height (index 1) while idle; the
// value is clamped to [3, MAX_ROW_LENGTH] or [3, 1024] and the tile restarts.
// Throughput: one word per cycle. Each word passes the sample, corner, slope
// and output registers. Sample and corner line stores are single-port-write
// RAMs with a registered read; the corner write at the end of a row is held
// back to the first sample of the next row so only one write goes per cycle.
// All stages advance together whenever the output register is empty or
// taken; a stalled receiver holds the whole pipe and drops coarse.ready.
// Reset: width and height 1024, tile position zero, pipe empty. Line store
// contents are not cleared; each entry is written before it is used.
`default_nettype none

module limited_2x_prolongation_2d_core import lp2d_pkg::*; #(
    parameter int MAX_ROW_LENGTH = 1024
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]       cfg_data,
    lp2d_in_if.sink                        coarse,
    lp2d_out_if.source                     fine
);

    localparam int XW = $clog2(MAX_ROW_LENGTH);
    localparam int WW = (XW + 1 > CFG_BITS) ? XW + 1 : CFG_BITS;
    localparam logic [WW-1:0] W_MAX = WW'(MAX_ROW_LENGTH);

    function automatic logic [XW-1:0] width_last(logic [CFG_BITS-1:0] v);
        logic [WW-1:0] w;
        w = WW'(v);
        if (w < WW'(TILE_MIN))
        begin
            w = WW'(TILE_MIN);
        end
        if (w > W_MAX)
        begin
            w = W_MAX;
        end
        return XW'(w - 1'b1);
    endfunction

    function automatic coord_t height_last(logic [CFG_BITS-1:0] v);
        logic [CFG_BITS-1:0] h;
        h = v;
        if (h < TILE_MIN)
        begin
            h = TILE_MIN;
        end
        if (h > MAX_ROWS)
        begin
            h = MAX_ROWS;
        end
        return COORD_BITS'(h - 1'b1);
    endfunction

    // tile geometry and position
    logic [XW-1:0] w_last_reg;
    coord_t        h_last_reg;
    logic [XW-1:0] col_reg;
    logic [XW-1:0] col_next;
    coord_t        row_reg;
    coord_t        row_next;

    // line stores
    sample_t sample_mem [MAX_ROW_LENGTH];
    fine_t   corner_mem [MAX_ROW_LENGTH];
    sample_t up_rd_reg;
    fine_t   c10_rd_reg;
    logic [XW-1:0] c_rd_addr;

    // sample stage
    logic          s1_valid_reg;
    sample_t       s1_sample_reg;
    logic [XW-1:0] s1_x_reg;
    coord_t        s1_y_reg;

    // running state
    sample_t       prev_sample_reg;
    sample_t       prev_upper_reg;
    fine_t         prev_corner_reg;
    fine_t         prev_c10_reg;
    logic          pend_valid_reg;
    logic [XW-1:0] pend_addr_reg;
    fine_t         pend_data_reg;

    // corner stage
    logic   s2_valid_reg;
    fine_t  s2_fb_reg;
    fine_t  s2_c00_reg;
    fine_t  s2_c10_reg;
    fine_t  s2_c01_reg;
    fine_t  s2_c11_reg;
    coord_t s2_col_reg;
    coord_t s2_row_reg;
    logic   s2_done_reg;

    // slope stage
    logic   s3_valid_reg;
    fine_t  s3_fb_reg;
    slope_t s3_df0_reg;
    slope_t s3_df1_reg;
    coord_t s3_col_reg;
    coord_t s3_row_reg;
    logic   s3_done_reg;

    // output register
    logic   out_valid_reg;
    fine_t  out_ll_reg;
    fine_t  out_hl_reg;
    fine_t  out_lh_reg;
    fine_t  out_hh_reg;
    coord_t out_col_reg;
    coord_t out_row_reg;
    logic   out_done_reg;

    logic    adv;
    logic    accept;
    logic    proc;
    logic    x_ge1;
    logic    x_ge2;
    logic    y_ge1;
    logic    y_ge2;
    logic    row_end;
    logic    corner_wr;
    sample_t up;
    fine_t   corner;
    fine_t   fb;
    slope_t  fb_wide;
    slope_t  ll_wide;
    slope_t  hl_wide;
    slope_t  lh_wide;
    slope_t  hh_wide;

    assign adv          = !out_valid_reg || fine.ready;
    assign accept       = coarse.valid && adv;
    assign coarse.ready = adv;
    assign proc         = s1_valid_reg && adv;

    always_comb
    begin
        if (col_reg == w_last_reg)
        begin
            col_next = '0;
            row_next = (row_reg == h_last_reg) ? '0 : row_reg + 1'b1;
        end
        else
        begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    assign c_rd_addr = (col_reg == '0) ? '0 : col_reg - 1'b1;

    assign x_ge1     = s1_x_reg != '0;
    assign x_ge2     = s1_x_reg > XW'(1);
    assign y_ge1     = s1_y_reg != '0;
    assign y_ge2     = s1_y_reg > COORD_BITS'(1);
    assign row_end   = s1_x_reg == w_last_reg;
    assign corner_wr = proc && x_ge2 && y_ge1;
    assign up        = y_ge1 ? up_rd_reg : '0;
    assign corner    = FINE_BITS'(prev_upper_reg) + FINE_BITS'(up)
                     + FINE_BITS'(prev_sample_reg) + FINE_BITS'(s1_sample_reg);
    assign fb        = fine_t'({prev_upper_reg, 2'b00});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= width_last(TILE_RESET);
            h_last_reg <= height_last(TILE_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_write && (cfg_index == CFG_TILE_WIDTH || cfg_index == CFG_TILE_HEIGHT))
        begin
            if (cfg_index == CFG_TILE_WIDTH)
            begin
                w_last_reg <= width_last(cfg_data);
            end
            else
            begin
                h_last_reg <= height_last(cfg_data);
            end
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_mem[col_reg] <= coarse.coarse_sample;
            up_rd_reg           <= sample_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (corner_wr)
        begin
            corner_mem[s1_x_reg - XW'(2)] <= prev_corner_reg;
        end
        else if (proc && pend_valid_reg)
        begin
            corner_mem[pend_addr_reg] <= pend_data_reg;
        end
        if (accept)
        begin
            c10_rd_reg <= corner_mem[c_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            prev_sample_reg <= '0;
            prev_upper_reg  <= '0;
            prev_corner_reg <= '0;
            pend_valid_reg  <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= coarse.valid;
            s2_valid_reg  <= s1_valid_reg && x_ge2 && y_ge2;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s1_valid_reg)
            begin
                prev_sample_reg <= s1_sample_reg;
                prev_upper_reg  <= up;
                if (x_ge1 && y_ge1)
                begin
                    prev_corner_reg <= corner;
                end
                if (x_ge1 && y_ge1 && row_end)
                begin
                    pend_valid_reg <= 1'b1;
                end
                else if (!corner_wr)
                begin
                    pend_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= coarse.coarse_sample;
            s1_x_reg      <= col_reg;
            s1_y_reg      <= row_reg;
        end
        if (proc)
        begin
            prev_c10_reg  <= c10_rd_reg;
            pend_addr_reg <= s1_x_reg - 1'b1;
            if (row_end)
            begin
                pend_data_reg <= corner;
            end
        end
        if (adv)
        begin
            s2_fb_reg   <= fb;
            s2_c00_reg  <= prev_c10_reg;
            s2_c10_reg  <= c10_rd_reg;
            s2_c01_reg  <= prev_corner_reg;
            s2_c11_reg  <= corner;
            s2_col_reg  <= COORD_BITS'(s1_x_reg - 1'b1);
            s2_row_reg  <= s1_y_reg - 1'b1;
            s2_done_reg <= row_end && (s1_y_reg == h_last_reg);

            s3_fb_reg   <= s2_fb_reg;
            s3_df0_reg  <= limited_slope(s2_fb_reg, s2_c00_reg, s2_c11_reg);
            s3_df1_reg  <= limited_slope(s2_fb_reg, s2_c10_reg, s2_c01_reg);
            s3_col_reg  <= s2_col_reg;
            s3_row_reg  <= s2_row_reg;
            s3_done_reg <= s2_done_reg;

            out_ll_reg   <= ll_wide[FINE_BITS-1:0];
            out_hl_reg   <= hl_wide[FINE_BITS-1:0];
            out_lh_reg   <= lh_wide[FINE_BITS-1:0];
            out_hh_reg   <= hh_wide[FINE_BITS-1:0];
            out_col_reg  <= s3_col_reg;
            out_row_reg  <= s3_row_reg;
            out_done_reg <= s3_done_reg;
        end
    end

    assign fb_wide = SLOPE_BITS'(s3_fb_reg);
    assign ll_wide = fb_wide - s3_df0_reg;
    assign hl_wide = fb_wide - s3_df1_reg;
    assign lh_wide = fb_wide + s3_df1_reg;
    assign hh_wide = fb_wide + s3_df0_reg;

    assign fine.valid          = out_valid_reg;
    assign fine.fine_low_low   = out_ll_reg;
    assign fine.fine_high_low  = out_hl_reg;
    assign fine.fine_low_high  = out_lh_reg;
    assign fine.fine_high_high = out_hh_reg;
    assign fine.cell_column    = out_col_reg;
    assign fine.cell_row       = out_row_reg;
    assign fine.tile_done      = out_done_reg;

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= w_last_reg)
        else $error("column count past end of row");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        fine.valid |-> (fine.cell_column != '0 && fine.cell_row != '0))
        else $error("edge cell emitted");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !adv |=> s1_valid_reg && $stable(s1_x_reg) && $stable(up_rd_reg))
        else $error("sample stage lost while stalled");

    a_pipe_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s2_valid_reg |=> s3_valid_reg)
        else $error("corner stage dropped a cell");

endmodule

`default_nettype wire

>>> test/lp2d_refine_scoreboard.sv
module lp2d_refine_scoreboard import lp2d_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]       cfg_data,
    lp2d_in_if                             coarse,
    lp2d_out_if                            fine,
    output int                             failures,
    output int                             outstanding,
    output int                             compared
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LIMIT = 1024;

    typedef struct {
        fine_t  low_low;
        fine_t  high_low;
        fine_t  low_high;
        fine_t  high_high;
        coord_t column;
        coord_t row;
        logic   done;
    } refined_cell_t;

    refined_cell_t       due_cells[$];
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    int                  col_pos;
    int                  row_pos;
    int                  sample_store[ROW_LIMIT];
    int                  corner_store[ROW_LIMIT];
    int                  last_sample;
    int                  last_corner;
    int                  last_upper;

    function automatic int span(logic [CFG_BITS-1:0] v, int hi);
        if (int'(v) < int'(TILE_MIN))
        begin
            return int'(TILE_MIN);
        end
        if (int'(v) > hi)
        begin
            return hi;
        end
        return int'(v);
    endfunction

    // slope towards a, bounded by the distance to b; zero at a peak or trough
    function automatic int bounded_slope(int fb, int a, int b);
        int da;
        int db;
        int m;
        da = fb - a;
        db = b - fb;
        m  = (da < 0) ? -da : da;
        if (((db < 0) ? -db : db) < m)
        begin
            m = (db < 0) ? -db : db;
        end
        if ((da > 0 && db < 0) || (da < 0 && db > 0))
        begin
            return 0;
        end
        return (da < 0) ? -m : m;
    endfunction

    function automatic int field_diff(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t fine word %s: expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic refine_step(int s);
        int            w;
        int            h;
        int            up;
        int            corner;
        int            c00;
        int            c10;
        int            c01;
        int            fb;
        int            df0;
        int            df1;
        refined_cell_t next_cell;
        w  = span(width_reg, ROW_LIMIT);
        h  = span(height_reg, int'(MAX_ROWS));
        up = (row_pos >= 1) ? sample_store[col_pos] : 0;
        if (col_pos >= 1 && row_pos >= 1)
        begin
            corner = last_upper + up + last_sample + s;
            c01    = last_corner;
            c10    = corner_store[col_pos-1];
            c00    = (col_pos >= 2) ? corner_store[col_pos-2] : 0;
            if (col_pos >= 2 && row_pos >= 2)
            begin
                fb                  = last_upper * 4;
                df0                 = bounded_slope(fb, c00, corner);
                df1                 = bounded_slope(fb, c10, c01);
                next_cell.low_low   = fine_t'(fb - df0);
                next_cell.high_low  = fine_t'(fb - df1);
                next_cell.low_high  = fine_t'(fb + df1);
                next_cell.high_high = fine_t'(fb + df0);
                next_cell.column    = coord_t'(col_pos - 1);
                next_cell.row       = coord_t'(row_pos - 1);
                next_cell.done      = (col_pos == w - 1 && row_pos == h - 1);
                due_cells.push_back(next_cell);
            end
            if (col_pos >= 2)
            begin
                corner_store[col_pos-2] = last_corner;
            end
            if (col_pos == w - 1)
            begin
                corner_store[col_pos-1] = corner;
            end
            last_corner = corner;
        end
        sample_store[col_pos] = s;
        last_upper            = up;
        last_sample           = s;
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
            begin
                row_pos = 0;
            end
        end
    endtask

    task automatic check_cell();
        refined_cell_t want;
        int            bad;
        if (due_cells.size() == 0)
        begin
            $display("%0t fine word at cell (%0d,%0d): expected none, actual low_low %0d",
                     $time, fine.cell_column, fine.cell_row, fine.fine_low_low);
            failures++;
        end
        else
        begin
            want = due_cells.pop_front();
            bad  = field_diff("fine_low_low", want.low_low, fine.fine_low_low)
                 + field_diff("fine_high_low", want.high_low, fine.fine_high_low)
                 + field_diff("fine_low_high", want.low_high, fine.fine_low_high)
                 + field_diff("fine_high_high", want.high_high, fine.fine_high_high)
                 + field_diff("cell_column", want.column, fine.cell_column)
                 + field_diff("cell_row", want.row, fine.cell_row)
                 + field_diff("tile_done", want.done, fine.tile_done);
            if (bad != 0)
            begin
                failures++;
            end
            compared++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   = TILE_RESET;
            height_reg  = TILE_RESET;
            col_pos     = 0;
            row_pos     = 0;
            last_sample = 0;
            last_corner = 0;
            last_upper  = 0;
            for (int k = 0; k < ROW_LIMIT; k++)
            begin
                sample_store[k] = 0;
                corner_store[k] = 0;
            end
            due_cells.delete();
            failures    = 0;
            outstanding = 0;
            compared    = 0;
        end
        else
        begin
            if (fine.valid && fine.ready)
            begin
                check_cell();
            end
            // spare indexes leave the tile position alone
            if (cfg_write)
            begin
                if (cfg_index == CFG_TILE_WIDTH)
                begin
                    width_reg = cfg_data;
                    col_pos   = 0;
                    row_pos   = 0;
                end
                else if (cfg_index == CFG_TILE_HEIGHT)
                begin
                    height_reg = cfg_data;
                    col_pos    = 0;
                    row_pos    = 0;
                end
            end
            if (coarse.valid && coarse.ready)
            begin
                refine_step(int'(coarse.coarse_sample));
            end
            outstanding = due_cells.size();
        end
    end

endmodule

>>> test/limited_2x_prolongation_2d_core_test.sv
module limited_2x_prolongation_2d_core_test import lp2d_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {FILL_FULL, FILL_NARROW, FILL_RAMP, FILL_EXTREME} fill_t;
    typedef enum int {TAKE_ALL, TAKE_HALF, TAKE_QUARTER, TAKE_PERIODIC} take_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LOW  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HIGH = 2'd3;

    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    // three 3x3 tiles: steep monotone diagonal, deep trough, gentle diagonal
    localparam sample_t DIRECTED_WORDS[27] = '{
        SAMPLE_MIN, SAMPLE_MIN, 16'sd0,
        SAMPLE_MIN, 16'sd0,     SAMPLE_MAX,
        16'sd0,     SAMPLE_MAX, SAMPLE_MAX,
        SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
        SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX,
        SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
        16'sd0,     16'sd1000,  16'sd2000,
        16'sd1000,  16'sd2000,  16'sd3000,
        16'sd2000,  16'sd3000,  16'sd4000
    };

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]       cfg_data;

    lp2d_in_if  coarse_ch ();
    lp2d_out_if fine_ch ();

    int    failures;
    int    outstanding;
    int    compared;
    int    words_sent     = 0;
    int    settings_count = 0;
    int    burst_left     = 0;
    int    eff_width      = 1024;
    int    ramp_base;
    int    ramp_dx;
    int    ramp_dy;
    fill_t fill           = FILL_FULL;

    limited_2x_prolongation_2d_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coarse    (coarse_ch),
        .fine      (fine_ch)
    );

    lp2d_refine_scoreboard refine_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .coarse      (coarse_ch),
        .fine        (fine_ch),
        .failures    (failures),
        .outstanding (outstanding),
        .compared    (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: stall pattern steps through all, half, quarter and periodic taking
    initial
    begin
        int    tick;
        take_t take;
        tick = 0;
        fine_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            take = take_t'((tick / 97) % 4);
            case (take)
                TAKE_ALL:     fine_ch.ready <= 1'b1;
                TAKE_HALF:    fine_ch.ready <= ($urandom_range(0, 1) == 1);
                TAKE_QUARTER: fine_ch.ready <= ($urandom_range(0, 3) == 0);
                default:      fine_ch.ready <= ((tick % 7) < 4);
            endcase
        end
    end

    function automatic int clamp_size(int v);
        return (v < 3) ? 3 : ((v > 1024) ? 1024 : v);
    endfunction

    task automatic send_word(sample_t s);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                coarse_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 16);
        end
        burst_left--;
        coarse_ch.valid         <= 1'b1;
        coarse_ch.coarse_sample <= s;
        @(posedge clk);
        while (!coarse_ch.ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic settle();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(bit set_w, int w, bit set_h, int h, bit spare);
        settle();
        if (set_w)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_TILE_WIDTH;
            cfg_data  <= CFG_BITS'(w);
            eff_width = clamp_size(w);
            @(posedge clk);
        end
        if (set_h)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_TILE_HEIGHT;
            cfg_data  <= CFG_BITS'(h);
            @(posedge clk);
        end
        if (spare)
        begin
            cfg_write <= 1'b1;
            cfg_index <= ($urandom_range(0, 1) == 1) ? CFG_SPARE_LOW : CFG_SPARE_HIGH;
            cfg_data  <= CFG_BITS'($urandom_range(0, 2047));
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_count++;
    endtask

    task automatic pick_fill();
        fill      = ($urandom_range(0, 2) == 0) ? fill_t'($urandom_range(0, 3)) : FILL_RAMP;
        ramp_base = int'($urandom_range(0, 40000)) - 20000;
        ramp_dx   = int'($urandom_range(0, 4000)) - 2000;
        ramp_dy   = int'($urandom_range(0, 4000)) - 2000;
    endtask

    task automatic stream(int count);
        int      v;
        sample_t s;
        for (int k = 0; k < count; k++)
        begin
            case (fill)
                FILL_FULL:   s = sample_t'($urandom_range(0, 65535));
                FILL_NARROW: s = sample_t'(int'($urandom_range(0, 4)) - 2);
                FILL_EXTREME:
                begin
                    case ($urandom_range(0, 3))
                        0:       s = SAMPLE_MIN;
                        1:       s = SAMPLE_MAX;
                        2:       s = '0;
                        default: s = '1;
                    endcase
                end
                default:
                begin
                    v = ramp_base + (k % eff_width) * ramp_dx + (k / eff_width) * ramp_dy
                      + int'($urandom_range(0, 6)) - 3;
                    v = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
                    s = sample_t'(v);
                end
            endcase
            send_word(s);
        end
        coarse_ch.valid <= 1'b0;
    endtask

    initial
    begin
        int choice;
        int w_raw;
        int h_raw;
        rst_n                   <= 1'b0;
        cfg_write               <= 1'b0;
        cfg_index               <= CFG_TILE_WIDTH;
        cfg_data                <= '0;
        coarse_ch.valid         <= 1'b0;
        coarse_ch.coarse_sample <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // undersized width and height clamp to 3x3
        configure(1'b1, 1, 1'b1, 2, 1'b1);
        for (int k = 0; k < 27; k++)
        begin
            send_word(DIRECTED_WORDS[k]);
        end
        coarse_ch.valid <= 1'b0;

        for (int phase = 0; phase < 10; phase++)
        begin
            case ($urandom_range(0, 5))
                0:       w_raw = $urandom_range(0, 2);
                1:       w_raw = $urandom_range(13, 40);
                default: w_raw = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 5))
                0:       h_raw = $urandom_range(0, 2);
                1:       h_raw = $urandom_range(1025, 2047);
                default: h_raw = $urandom_range(3, 8);
            endcase
            choice = $urandom_range(0, 7);
            case (choice)
                0:       configure(1'b0, 0, 1'b0, 0, 1'b1);
                1:       configure(1'b1, w_raw, 1'b0, 0, $urandom_range(0, 1) == 1);
                2:       configure(1'b0, 0, 1'b1, h_raw, $urandom_range(0, 1) == 1);
                default: configure(1'b1, w_raw, 1'b1, h_raw, $urandom_range(0, 1) == 1);
            endcase
            pick_fill();
            stream($urandom_range(20, 70));
        end

        // oversized width clamps to the longest row
        configure(1'b1, 2047, 1'b1, 3, 1'b0);
        pick_fill();
        stream(40);

        // tallest tile, first rows only
        configure(1'b1, 3, 1'b1, 1024, 1'b0);
        pick_fill();
        stream(36);

        settle();
        $display("covered %0d coarse words over %0d tile settings; %0d fine words compared",
                 words_sent, settings_count, compared);
        if (failures == 0 && outstanding == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/lp2d_pkg.sv
hdl/lp2d_in_if.sv
hdl/lp2d_out_if.sv
hdl/limited_2x_prolongation_2d_core.sv
test/lp2d_refine_scoreboard.sv
test/limited_2x_prolongation_2d_core_test.sv
